// ----- design/y86ex_pkg.sv -----
// Shared types and codes for the Y86-64 execute stage.
`timescale 1ns / 1ps
`default_nettype none

package y86ex_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int VAL_W         = 64;

  // Instruction codes
  localparam logic [3:0] IC_HALT   = 4'd0;
  localparam logic [3:0] IC_NOP    = 4'd1;
  localparam logic [3:0] IC_RRMOVQ = 4'd2;
  localparam logic [3:0] IC_IRMOVQ = 4'd3;
  localparam logic [3:0] IC_RMMOVQ = 4'd4;
  localparam logic [3:0] IC_MRMOVQ = 4'd5;
  localparam logic [3:0] IC_OPQ    = 4'd6;
  localparam logic [3:0] IC_JXX    = 4'd7;
  localparam logic [3:0] IC_CALL   = 4'd8;
  localparam logic [3:0] IC_RET    = 4'd9;
  localparam logic [3:0] IC_PUSHQ  = 4'd10;
  localparam logic [3:0] IC_POPQ   = 4'd11;

  // ALU function codes carried in ifun for OPq
  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_XOR = 4'd3;

  // Condition codes carried in ifun for jXX and cmov
  localparam logic [3:0] C_ALWAYS = 4'd0;
  localparam logic [3:0] C_LE     = 4'd1;
  localparam logic [3:0] C_LT     = 4'd2;
  localparam logic [3:0] C_EQ     = 4'd3;
  localparam logic [3:0] C_NE     = 4'd4;
  localparam logic [3:0] C_GE     = 4'd5;
  localparam logic [3:0] C_GT     = 4'd6;

  // Status codes
  localparam logic [1:0] STAT_AOK = 2'd0;
  localparam logic [1:0] STAT_HLT = 2'd1;
  localparam logic [1:0] STAT_ADR = 2'd2;
  localparam logic [1:0] STAT_INS = 2'd3;

  localparam logic [3:0] REG_NONE = 4'd15;

  // Condition flags kept between instructions
  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } flags_t;

  // Input request, last field in the lowest bits (216 bits)
  typedef struct packed {
    logic [1:0]       pad;
    logic [1:0]       wb_stage_status;
    logic [1:0]       mem_stage_status;
    logic [3:0]       dest_mem;
    logic [3:0]       dest_exec;
    logic [VAL_W-1:0] constant_value;
    logic [VAL_W-1:0] reg_b_value;
    logic [VAL_W-1:0] reg_a_value;
    logic [3:0]       ifun;
    logic [3:0]       icode;
    logic [1:0]       instr_status;
  } in_item_t;

  // Result request, last field in the lowest bits (144 bits)
  typedef struct packed {
    logic             bubble_next;
    logic [3:0]       out_dest_mem;
    logic [3:0]       out_dest_exec;
    logic [VAL_W-1:0] out_reg_a;
    logic [VAL_W-1:0] alu_result;
    logic             cond_taken;
    logic [3:0]       out_icode;
    logic [1:0]       out_status;
  } out_item_t;

  // Flag update from the ALU toward the flag register
  typedef struct packed {
    logic   wr_en;
    flags_t flags;
  } flag_upd_t;

endpackage

`default_nettype wire

// ----- design/y86_execute_stage_unit.sv -----
// Y86-64 execute stage: streaming wrapper with input and result registers and the flag register.
`timescale 1ns / 1ps
`default_nettype none

// Execute stage of a Y86-64 pipeline. Each request on the slave stream is one
// decoded instruction; each request on the master stream is its execute result.
// The unit takes one instruction per clock unless the master side stalls. The
// path is an input register, then a single pass through operand select, ALU, flag and
// condition logic, then a result register. Both registers advance whenever the
// result register is empty or being taken, so a stalled master side holds at
// most two instructions before tready drops. The SF/ZF/OF flags live in a
// register written when an OPq leaves the input register (unless the memory or
// writeback status is an exception), so the very next instruction already sees
// them. Arithmetic runs on WORD_BITS bits; alu_result is zero-extended to 64.
// Reset clears the flags and both valid bits.

module y86_execute_stage_unit #(
  parameter int WORD_BITS = y86ex_pkg::WORD_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // instr_status[1:0], icode[5:2], ifun[9:6], reg_a_value[73:10],
  // reg_b_value[137:74], constant_value[201:138], dest_exec[205:202],
  // dest_mem[209:206], mem_stage_status[211:210], wb_stage_status[213:212], pad[215:214]
  input  wire logic [215:0] s_axis_tdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // out_status[1:0], out_icode[5:2], cond_taken[6], alu_result[70:7],
  // out_reg_a[134:71], out_dest_exec[138:135], out_dest_mem[142:139], bubble_next[143]
  output logic [143:0]      m_axis_tdata_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i
);

  y86ex_pkg::in_item_t  in_q;
  logic                 in_valid_q;
  y86ex_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q;
  y86ex_pkg::flags_t    flags_q;
  y86ex_pkg::flag_upd_t flag_upd;

  logic advance;   // result register can take a new value
  logic s_accept;  // slave request taken this clock

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= y86ex_pkg::in_item_t'(s_axis_tdata_i);
    end
  end

  y86ex_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .item_i     (in_q),
    .flags_i    (flags_q),
    .result_o   (out_d),
    .flag_upd_o (flag_upd)
  );

  // result register and flags; flags move with the instruction that wrote them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q && flag_upd.wr_en) begin
        flags_q <= flag_upd.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = out_valid_q;

`ifndef SYNTHESIS
  // Flags change only when an OPq leaves the input register
  a_flags_only_on_opq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q != $past(flags_q)) |->
      $past(advance && in_valid_q && (in_q.icode == y86ex_pkg::IC_OPQ)))
    else $error("flags changed without an OPq");

  // A failed cmov never keeps its ALU destination
  a_cmov_fail_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.out_icode == y86ex_pkg::IC_RRMOVQ) && !out_q.cond_taken) |->
      (out_q.out_dest_exec == y86ex_pkg::REG_NONE))
    else $error("failed cmov kept its destination");

  // Condition is reported only for jumps and cmov
  a_cond_only_jxx_cmov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cond_taken) |->
      ((out_q.out_icode == y86ex_pkg::IC_RRMOVQ) || (out_q.out_icode == y86ex_pkg::IC_JXX)))
    else $error("condition taken for a non-branch instruction");
`endif

endmodule

`default_nettype wire

// ----- design/y86ex_alu.sv -----
// Operand select, ALU, flag generation and condition check for one instruction.
`timescale 1ns / 1ps
`default_nettype none

module y86ex_alu #(
  parameter int WORD_BITS = y86ex_pkg::WORD_BITS_DEF
) (
  input  wire y86ex_pkg::in_item_t  item_i,
  input  wire y86ex_pkg::flags_t    flags_i,
  output y86ex_pkg::out_item_t      result_o,
  output y86ex_pkg::flag_upd_t      flag_upd_o
);

  localparam logic [WORD_BITS-1:0] PLUS8  = WORD_BITS'(8);
  localparam logic [WORD_BITS-1:0] MINUS8 = '0 - PLUS8;

  logic [WORD_BITS-1:0] op_a, op_b, res;
  logic [3:0]           alu_fn;
  logic                 ovf, cnd, lt, downstream_exc, is_opq;

  assign is_opq         = (item_i.icode == y86ex_pkg::IC_OPQ);
  assign downstream_exc = (item_i.mem_stage_status != y86ex_pkg::STAT_AOK) ||
                          (item_i.wb_stage_status != y86ex_pkg::STAT_AOK);

  always_comb begin
    case (item_i.icode) inside
      y86ex_pkg::IC_RRMOVQ, y86ex_pkg::IC_OPQ:
        op_a = item_i.reg_a_value[WORD_BITS-1:0];
      y86ex_pkg::IC_IRMOVQ, y86ex_pkg::IC_RMMOVQ, y86ex_pkg::IC_MRMOVQ:
        op_a = item_i.constant_value[WORD_BITS-1:0];
      y86ex_pkg::IC_CALL, y86ex_pkg::IC_PUSHQ:
        op_a = MINUS8;
      y86ex_pkg::IC_RET, y86ex_pkg::IC_POPQ:
        op_a = PLUS8;
      default:
        op_a = '0;
    endcase
  end

  always_comb begin
    case (item_i.icode) inside
      y86ex_pkg::IC_RMMOVQ, y86ex_pkg::IC_MRMOVQ, y86ex_pkg::IC_OPQ,
      y86ex_pkg::IC_CALL, y86ex_pkg::IC_RET, y86ex_pkg::IC_PUSHQ, y86ex_pkg::IC_POPQ:
        op_b = item_i.reg_b_value[WORD_BITS-1:0];
      default:
        op_b = '0;
    endcase
  end

  assign alu_fn = is_opq ? item_i.ifun : y86ex_pkg::ALU_ADD;

  // Unused function codes fall into AND
  always_comb begin
    case (alu_fn)
      y86ex_pkg::ALU_ADD: begin
        res = op_a + op_b;
        ovf = (op_a[WORD_BITS-1] == op_b[WORD_BITS-1]) &&
              (res[WORD_BITS-1] != op_a[WORD_BITS-1]);
      end
      y86ex_pkg::ALU_SUB: begin
        res = op_b - op_a;
        ovf = (op_a[WORD_BITS-1] != op_b[WORD_BITS-1]) &&
              (res[WORD_BITS-1] != op_b[WORD_BITS-1]);
      end
      y86ex_pkg::ALU_XOR: begin
        res = op_a ^ op_b;
        ovf = 1'b0;
      end
      y86ex_pkg::ALU_AND: begin
        res = op_a & op_b;
        ovf = 1'b0;
      end
      default: begin
        res = op_a & op_b;
        ovf = 1'b0;
      end
    endcase
  end

  // Condition from the kept flags; unknown codes are never taken
  assign lt = flags_i.sf ^ flags_i.of;

  always_comb begin
    cnd = 1'b0;
    if ((item_i.icode == y86ex_pkg::IC_RRMOVQ) || (item_i.icode == y86ex_pkg::IC_JXX)) begin
      case (item_i.ifun)
        y86ex_pkg::C_ALWAYS: cnd = 1'b1;
        y86ex_pkg::C_LE:     cnd = lt | flags_i.zf;
        y86ex_pkg::C_LT:     cnd = lt;
        y86ex_pkg::C_EQ:     cnd = flags_i.zf;
        y86ex_pkg::C_NE:     cnd = ~flags_i.zf;
        y86ex_pkg::C_GE:     cnd = ~lt;
        y86ex_pkg::C_GT:     cnd = ~lt & ~flags_i.zf;
        default:             cnd = 1'b0;
      endcase
    end
  end

  assign flag_upd_o.wr_en    = is_opq && !downstream_exc;
  assign flag_upd_o.flags.zf = (res == '0);
  assign flag_upd_o.flags.sf = res[WORD_BITS-1];
  assign flag_upd_o.flags.of = ovf;

  assign result_o.out_status    = item_i.instr_status;
  assign result_o.out_icode     = item_i.icode;
  assign result_o.cond_taken    = cnd;
  assign result_o.alu_result    = y86ex_pkg::VAL_W'(res);
  assign result_o.out_reg_a     = item_i.reg_a_value;
  assign result_o.out_dest_exec = ((item_i.icode == y86ex_pkg::IC_RRMOVQ) && !cnd) ?
                                  y86ex_pkg::REG_NONE : item_i.dest_exec;
  assign result_o.out_dest_mem  = item_i.dest_mem;
  assign result_o.bubble_next   = downstream_exc;

endmodule

`default_nettype wire
